>>> hdl/grq_pkg.sv
// Shared types, sizes and codes for the grouped ready queue.
`timescale 1ns / 1ps
`default_nettype none

package grq_pkg;

    // Storage geometry
    localparam int NUM_GROUPS  = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int GRP_W = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths
    localparam int SEQ_W    = 32;
    localparam int HANDLE_W = 16;
    localparam int KIND_W   = 3;
    localparam int GFIELD_W = 2;
    localparam int LIMIT_W  = 5;
    localparam int OCNT_W   = 5;
    localparam int CIDX_W   = 2;
    localparam int CDATA_W  = 5;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMP_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TAKE      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SQUASH    = 3'd4;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_FILL_LIMIT   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MULDIV_GROUP = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_FPADD_GROUP  = 2'd2;

    // Controls for one cell
    typedef struct packed {
        logic load;   // write the incoming entry if selected
        logic mark;   // flag the entry if newer than the squash bound
        logic step;   // shift from the upper neighbor where the chain says so
    } grq_cell_ctrl_t;

    // Controls for one group row
    typedef struct packed {
        logic insert;
        logic take;
        logic squash_step;
        logic mark;
    } grq_row_ctrl_t;

    // Status of one group row
    typedef struct packed {
        logic [CNT_W-1:0]    count;
        logic                chain_out;
        logic [SEQ_W-1:0]    head_seq;
        logic [HANDLE_W-1:0] head_handle;
    } grq_row_stat_t;

    // Fold an occupancy count into the 5-bit result field
    function automatic logic [OCNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[OCNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/grq_cell.sv
// One queue cell: holds an entry and its squash flag, shifts from its upper neighbor.
`timescale 1ns / 1ps
`default_nettype none

module grq_cell
    import grq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire grq_cell_ctrl_t      ctrl,
    input  wire logic                occ,
    input  wire logic                sel,
    input  wire logic [SEQ_W-1:0]    new_seq,
    input  wire logic [HANDLE_W-1:0] new_handle,
    input  wire logic [SEQ_W-1:0]    up_seq,
    input  wire logic [HANDLE_W-1:0] up_handle,
    input  wire logic                up_dead,
    input  wire logic                shift_in,
    output logic                     shift_out,
    output logic [SEQ_W-1:0]         seq,
    output logic [HANDLE_W-1:0]      handle,
    output logic                     dead
);

    logic [SEQ_W-1:0]    seq_reg;
    logic [SEQ_W-1:0]    seq_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic                dead_reg;
    logic                dead_next;
    logic                shift;

    // Extend the collapse chain: a flagged live entry makes everything above it move down
    assign shift     = shift_in | (dead_reg & occ);
    assign shift_out = shift;

    // Choose next contents
    always_comb
    begin
        seq_next    = seq_reg;
        handle_next = handle_reg;
        dead_next   = dead_reg;
        if (ctrl.mark)
        begin
            dead_next = (seq_reg > new_seq);
        end
        else if (ctrl.load && sel)
        begin
            seq_next    = new_seq;
            handle_next = new_handle;
            dead_next   = 1'b0;
        end
        else if (ctrl.step && shift)
        begin
            seq_next    = up_seq;
            handle_next = up_handle;
            dead_next   = up_dead;
        end
    end

    // Hold the squash flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg <= 1'b0;
        end
        else
        begin
            dead_reg <= dead_next;
        end
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        seq_reg    <= seq_next;
        handle_reg <= handle_next;
    end

    assign seq    = seq_reg;
    assign handle = handle_reg;
    assign dead   = dead_reg;

endmodule

`default_nettype wire

>>> hdl/grq_row.sv
// One group queue: a row of cells with head at cell 0 and an occupancy counter.
`timescale 1ns / 1ps
`default_nettype none

module grq_row
    import grq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire grq_row_ctrl_t       ctrl,
    input  wire logic [SEQ_W-1:0]    new_seq,
    input  wire logic [HANDLE_W-1:0] new_handle,
    output grq_row_stat_t            stat
);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    grq_cell_ctrl_t      cell_ctrl;
    logic                step_en;

    logic [SEQ_W-1:0]    c_seq    [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] c_handle [QUEUE_DEPTH];
    logic                c_dead   [QUEUE_DEPTH];
    logic                chain    [QUEUE_DEPTH+1];

    // Take seeds the chain at the head; squash steps rely on flagged entries alone
    assign step_en        = ctrl.take | ctrl.squash_step;
    assign chain[0]       = ctrl.take;
    assign cell_ctrl.load = ctrl.insert;
    assign cell_ctrl.mark = ctrl.mark;
    assign cell_ctrl.step = step_en;

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic [SEQ_W-1:0]    up_seq;
            logic [HANDLE_W-1:0] up_handle;
            logic                up_dead;

            if (i == QUEUE_DEPTH - 1)
            begin : g_top
                assign up_seq    = '0;
                assign up_handle = '0;
                assign up_dead   = 1'b0;
            end
            else
            begin : g_mid
                assign up_seq    = c_seq[i+1];
                assign up_handle = c_handle[i+1];
                assign up_dead   = c_dead[i+1];
            end

            grq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .occ        (CNT_W'(i) < count_reg),
                .sel        (CNT_W'(i) == count_reg),
                .new_seq    (new_seq),
                .new_handle (new_handle),
                .up_seq     (up_seq),
                .up_handle  (up_handle),
                .up_dead    (up_dead),
                .shift_in   (chain[i]),
                .shift_out  (chain[i+1]),
                .seq        (c_seq[i]),
                .handle     (c_handle[i]),
                .dead       (c_dead[i])
            );
        end
    endgenerate

    // Advance the count: one up per insert, one down per collapse step
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (step_en && chain[QUEUE_DEPTH])
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.count       = count_reg;
    assign stat.chain_out   = chain[QUEUE_DEPTH];
    assign stat.head_seq    = c_seq[0];
    assign stat.head_handle = c_handle[0];

endmodule

`default_nettype wire

>>> hdl/grouped_ready_queue_with_squash.sv
// Top level: group rows, configuration registers, item control and result word register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------------------
//   in      | to block  | in_valid / in_stall    | kind, group, seq_num, handle
//   out     | from block| out_valid / out_stall  | head_valid, head_seq, head_handle,
//           |           |                        | placed_group, dropped, any_full,
//           |           |                        | group_full, group_count
//   cfg     | to block  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Insert, peek, take and unused kinds: the accept edge updates the rows, and the result
// word then moves into the output register once that register is free.
// A squash flags every entry newer than its sequence number; each row then collapses one
// flagged entry per cycle through its cell chain until none is left, and the result follows.
// Reset empties every group and loads fill_limit 16, muldiv_group 1, fpadd_group 2.
// A stalled result word holds in its register while the next word is accepted; a
// further result waits until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module grouped_ready_queue_with_squash
    import grq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [KIND_W-1:0]   kind,
    input  wire logic [GFIELD_W-1:0] group,
    input  wire logic [SEQ_W-1:0]    seq_num,
    input  wire logic [HANDLE_W-1:0] handle,

    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     head_valid,
    output logic [SEQ_W-1:0]         head_seq,
    output logic [HANDLE_W-1:0]      head_handle,
    output logic [GFIELD_W-1:0]      placed_group,
    output logic                     dropped,
    output logic                     any_full,
    output logic                     group_full,
    output logic [OCNT_W-1:0]        group_count,

    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [CDATA_W-1:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SQUASH = 2'd1;
    localparam logic [1:0] ST_RESULT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;

    logic [LIMIT_W-1:0]  fill_limit_reg;
    logic [GFIELD_W-1:0] muldiv_group_reg;
    logic [GFIELD_W-1:0] fpadd_group_reg;

    grq_row_ctrl_t       row_ctrl [NUM_GROUPS];
    grq_row_stat_t       row_stat [NUM_GROUPS];

    logic                accept;
    logic [31:0]         lim;
    logic                is_ins;
    logic [GFIELD_W-1:0] addr;
    logic                addr_drop;
    logic                hv;
    logic                any_kill;
    logic                out_load;

    logic                pend_hv_reg;
    logic [SEQ_W-1:0]    pend_seq_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;
    logic [GFIELD_W-1:0] pend_placed_reg;
    logic                pend_drop_reg;
    logic [GFIELD_W-1:0] pend_addr_reg;

    logic                out_valid_reg;
    logic                head_valid_reg;
    logic [SEQ_W-1:0]    head_seq_reg;
    logic [HANDLE_W-1:0] head_handle_reg;
    logic [GFIELD_W-1:0] placed_group_reg;
    logic                dropped_reg;
    logic                any_full_reg;
    logic                group_full_reg;
    logic [OCNT_W-1:0]   group_count_reg;

    // Group field to row index; only valid where the group has storage
    function automatic logic has_row(input logic [GFIELD_W-1:0] g);
        return (32'(g) < 32'(NUM_GROUPS));
    endfunction

    function automatic logic [GRP_W-1:0] row_idx(input logic [GFIELD_W-1:0] g);
        return GRP_W'(g);
    endfunction

    function automatic logic [CNT_W-1:0] count_of(input logic [GFIELD_W-1:0] g,
                                                  input logic [CNT_W-1:0] c);
        return has_row(g) ? c : '0;
    endfunction

    logic [CNT_W-1:0] cnt_muldiv;
    logic [CNT_W-1:0] cnt_fpadd;
    logic [CNT_W-1:0] cnt_grp;
    logic [CNT_W-1:0] cnt_addr;
    logic [CNT_W-1:0] cnt_pend;

    assign cnt_muldiv = count_of(muldiv_group_reg, row_stat[row_idx(muldiv_group_reg)].count);
    assign cnt_fpadd  = count_of(fpadd_group_reg, row_stat[row_idx(fpadd_group_reg)].count);
    assign cnt_grp    = count_of(group, row_stat[row_idx(group)].count);
    assign cnt_pend   = count_of(pend_addr_reg, row_stat[row_idx(pend_addr_reg)].count);

    // Effective full threshold: min(fill_limit, depth)
    assign lim = (32'(fill_limit_reg) > 32'(QUEUE_DEPTH)) ? 32'(QUEUE_DEPTH)
                                                          : 32'(fill_limit_reg);

    // Pick the target group for inserts
    assign is_ins    = (kind == KIND_INSERT) || (kind == KIND_EMP_INSERT);
    assign addr      = (kind == KIND_EMP_INSERT)
                       ? ((cnt_muldiv < cnt_fpadd) ? muldiv_group_reg : fpadd_group_reg)
                       : group;
    assign cnt_addr  = count_of(addr, row_stat[row_idx(addr)].count);
    assign addr_drop = !has_row(addr) || (32'(cnt_addr) >= lim);
    assign hv        = has_row(group) && (cnt_grp != '0);

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // Drive the rows
    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            row_ctrl[g].insert      = accept && is_ins && !addr_drop
                                      && (32'(addr) == 32'(g));
            row_ctrl[g].take        = accept && (kind == KIND_TAKE) && hv
                                      && (32'(group) == 32'(g));
            row_ctrl[g].mark        = accept && (kind == KIND_SQUASH);
            row_ctrl[g].squash_step = (state_reg == ST_SQUASH);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_GROUPS; gi++)
        begin : g_row
            grq_row u_row (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (row_ctrl[gi]),
                .new_seq    (seq_num),
                .new_handle (handle),
                .stat       (row_stat[gi])
            );
        end
    endgenerate

    // Any row still holding a flagged live entry
    always_comb
    begin
        any_kill = 1'b0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            any_kill = any_kill | row_stat[g].chain_out;
        end
    end

    assign out_load = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);

    // Sequence the item
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (kind == KIND_SQUASH) ? ST_SQUASH : ST_RESULT;
                end
            end
            ST_SQUASH:
            begin
                if (!any_kill)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            fill_limit_reg   <= LIMIT_W'(16);
            muldiv_group_reg <= GFIELD_W'(1);
            fpadd_group_reg  <= GFIELD_W'(2);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FILL_LIMIT:   fill_limit_reg   <= cfg_data;
                    CFG_MULDIV_GROUP: muldiv_group_reg <= cfg_data[GFIELD_W-1:0];
                    CFG_FPADD_GROUP:  fpadd_group_reg  <= cfg_data[GFIELD_W-1:0];
                    default:          ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;

    // Capture the item's own result fields at accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (is_ins)
            begin
                pend_hv_reg     <= 1'b0;
                pend_seq_reg    <= '0;
                pend_handle_reg <= '0;
                pend_placed_reg <= addr;
                pend_drop_reg   <= addr_drop;
                pend_addr_reg   <= addr;
            end
            else if (((kind == KIND_PEEK) || (kind == KIND_TAKE)) && hv)
            begin
                pend_hv_reg     <= 1'b1;
                pend_seq_reg    <= row_stat[row_idx(group)].head_seq;
                pend_handle_reg <= row_stat[row_idx(group)].head_handle;
                pend_placed_reg <= '0;
                pend_drop_reg   <= 1'b0;
                pend_addr_reg   <= group;
            end
            else
            begin
                pend_hv_reg     <= 1'b0;
                pend_seq_reg    <= '0;
                pend_handle_reg <= '0;
                pend_placed_reg <= '0;
                pend_drop_reg   <= 1'b0;
                pend_addr_reg   <= group;
            end
        end
    end

    // Load the result word with post-step fullness
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            head_valid_reg   <= pend_hv_reg;
            head_seq_reg     <= pend_seq_reg;
            head_handle_reg  <= pend_handle_reg;
            placed_group_reg <= pend_placed_reg;
            dropped_reg      <= pend_drop_reg;
            any_full_reg     <= !has_row(fpadd_group_reg) || (32'(cnt_fpadd) >= lim)
                                || !has_row(muldiv_group_reg) || (32'(cnt_muldiv) >= lim);
            group_full_reg   <= !has_row(pend_addr_reg) || (32'(cnt_pend) >= lim);
            group_count_reg  <= cnt_to_out(cnt_pend);
        end
    end

    assign out_valid    = out_valid_reg;
    assign head_valid   = head_valid_reg;
    assign head_seq     = head_seq_reg;
    assign head_handle  = head_handle_reg;
    assign placed_group = placed_group_reg;
    assign dropped      = dropped_reg;
    assign any_full     = any_full_reg;
    assign group_full   = group_full_reg;
    assign group_count  = group_count_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Testbench for the grouped ready queue: predicts each result word and checks it in order.
`timescale 1ns / 1ps

module tb_top;
    import grq_pkg::*;

    // Kinds and register index that the block defines as no-ops
    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_C = 3'd7;
    localparam logic [CIDX_W-1:0] CFG_SPARE     = 2'd3;

    localparam int PHASES       = 9;
    localparam int PHASE_WORDS  = 128;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [GFIELD_W-1:0] grp;
        logic [SEQ_W-1:0]    seq;
        logic [HANDLE_W-1:0] hdl;
    } queue_item_t;

    typedef struct packed {
        logic                head_valid;
        logic [SEQ_W-1:0]    head_seq;
        logic [HANDLE_W-1:0] head_handle;
        logic [GFIELD_W-1:0] placed_group;
        logic                dropped;
        logic                any_full;
        logic                group_full;
        logic [OCNT_W-1:0]   group_count;
    } result_word_t;

    // Shadow queues per group and the in-order store of predicted result words
    class ready_queue_scoreboard;
        logic [SEQ_W-1:0]    cell_seq    [NUM_GROUPS][QUEUE_DEPTH];
        logic [HANDLE_W-1:0] cell_handle [NUM_GROUPS][QUEUE_DEPTH];
        int unsigned         fill_cnt    [NUM_GROUPS];
        int unsigned         fill_limit;
        int unsigned         muldiv_grp;
        int unsigned         fpadd_grp;
        result_word_t        waiting[$];
        int unsigned         errors;
        int unsigned         words_out;
        int unsigned         drops;
        int unsigned         full_reports;

        function new();
            foreach (fill_cnt[g])
                fill_cnt[g] = 0;
            fill_limit   = 16;
            muldiv_grp   = 1;
            fpadd_grp    = 2;
            errors       = 0;
            words_out    = 0;
            drops        = 0;
            full_reports = 0;
        endfunction

        function void write_reg(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                CFG_FILL_LIMIT:   fill_limit = 32'(data);
                CFG_MULDIV_GROUP: muldiv_grp = 32'(data[1:0]);
                CFG_FPADD_GROUP:  fpadd_grp  = 32'(data[1:0]);
                default:          ;
            endcase
        endfunction

        function int unsigned occupancy(int unsigned g);
            return (g >= NUM_GROUPS) ? 0 : fill_cnt[g];
        endfunction

        function bit at_limit(int unsigned g);
            int unsigned lim;
            lim = (fill_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : fill_limit;
            if (g >= NUM_GROUPS)
                return 1'b1;
            return fill_cnt[g] >= lim;
        endfunction

        function int unsigned pending();
            return waiting.size();
        endfunction

        // Apply one accepted word to the shadow queues and queue its result
        function void note_item(queue_item_t it);
            result_word_t w;
            int unsigned  tgt;
            int unsigned  keep;
            w   = '0;
            tgt = 32'(it.grp);
            case (it.kind)
                KIND_INSERT, KIND_EMP_INSERT:
                begin
                    if (it.kind == KIND_EMP_INSERT)
                        tgt = (occupancy(muldiv_grp) < occupancy(fpadd_grp)) ?
                              muldiv_grp : fpadd_grp;
                    w.placed_group = GFIELD_W'(tgt);
                    if (at_limit(tgt))
                    begin
                        w.dropped = 1'b1;
                    end
                    else
                    begin
                        cell_seq[tgt][fill_cnt[tgt]]    = it.seq;
                        cell_handle[tgt][fill_cnt[tgt]] = it.hdl;
                        fill_cnt[tgt]++;
                    end
                end
                KIND_PEEK, KIND_TAKE:
                begin
                    if (tgt < NUM_GROUPS && fill_cnt[tgt] > 0)
                    begin
                        w.head_valid  = 1'b1;
                        w.head_seq    = cell_seq[tgt][0];
                        w.head_handle = cell_handle[tgt][0];
                        if (it.kind == KIND_TAKE)
                        begin
                            for (int i = 1; i < fill_cnt[tgt]; i++)
                            begin
                                cell_seq[tgt][i-1]    = cell_seq[tgt][i];
                                cell_handle[tgt][i-1] = cell_handle[tgt][i];
                            end
                            fill_cnt[tgt]--;
                        end
                    end
                end
                KIND_SQUASH:
                begin
                    // Keep entries at or below the bound, compacted in order
                    for (int g = 0; g < NUM_GROUPS; g++)
                    begin
                        keep = 0;
                        for (int i = 0; i < fill_cnt[g]; i++)
                        begin
                            if (cell_seq[g][i] <= it.seq)
                            begin
                                cell_seq[g][keep]    = cell_seq[g][i];
                                cell_handle[g][keep] = cell_handle[g][i];
                                keep++;
                            end
                        end
                        fill_cnt[g] = keep;
                    end
                end
                default: ;
            endcase
            w.any_full    = at_limit(fpadd_grp) || at_limit(muldiv_grp);
            w.group_full  = at_limit(tgt);
            w.group_count = OCNT_W'(occupancy(tgt));
            waiting = {waiting, w};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        // Match one result word against the oldest prediction
        function void check_word(result_word_t got);
            result_word_t want;
            words_out++;
            if (waiting.size() == 0)
            begin
                errors++;
                if (errors <= 30)
                    $display("%0t: result word with nothing predicted: %0h", $time, got);
                return;
            end
            want = waiting.pop_front();
            drops        += want.dropped;
            full_reports += want.group_full;
            compare_field("head_valid",   want.head_valid,   got.head_valid);
            compare_field("head_seq",     want.head_seq,     got.head_seq);
            compare_field("head_handle",  want.head_handle,  got.head_handle);
            compare_field("placed_group", want.placed_group, got.placed_group);
            compare_field("dropped",      want.dropped,      got.dropped);
            compare_field("any_full",     want.any_full,     got.any_full);
            compare_field("group_full",   want.group_full,   got.group_full);
            compare_field("group_count",  want.group_count,  got.group_count);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [KIND_W-1:0]   kind;
    logic [GFIELD_W-1:0] group;
    logic [SEQ_W-1:0]    seq_num;
    logic [HANDLE_W-1:0] handle;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                head_valid;
    logic [SEQ_W-1:0]    head_seq;
    logic [HANDLE_W-1:0] head_handle;
    logic [GFIELD_W-1:0] placed_group;
    logic                dropped;
    logic                any_full;
    logic                group_full;
    logic [OCNT_W-1:0]   group_count;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index;
    logic [CDATA_W-1:0]  cfg_data;

    ready_queue_scoreboard sb;
    int unsigned send_idle_pct = 35;
    int unsigned recv_idle_pct = 76;
    bit          hold_req      = 1'b0;
    bit          hold_taken    = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned words_in      = 0;
    int unsigned kind_seen [8];
    logic [SEQ_W-1:0] next_seq = 32'h0000_1000;

    grouped_ready_queue_with_squash i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .group        (group),
        .seq_num      (seq_num),
        .handle       (handle),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .head_valid   (head_valid),
        .head_seq     (head_seq),
        .head_handle  (head_handle),
        .placed_group (placed_group),
        .dropped      (dropped),
        .any_full     (any_full),
        .group_full   (group_full),
        .group_count  (group_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stall the result channel at random, or hold it off for a long stretch on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Check each result word taken from the block
    always @(posedge clk)
    begin : result_monitor
        result_word_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{head_valid, head_seq, head_handle, placed_group,
                    dropped, any_full, group_full, group_count};
            sb.check_word(got);
        end
    end

    function automatic queue_item_t op_item(logic [KIND_W-1:0] k, logic [GFIELD_W-1:0] g,
                                            logic [SEQ_W-1:0] s, logic [HANDLE_W-1:0] h);
        queue_item_t it;
        it = '{k, g, s, h};
        return it;
    endfunction

    // Mostly in-order inserts with takes and shallow squashes; a little noise
    function automatic queue_item_t make_random_item(bit insert_heavy);
        queue_item_t it;
        int unsigned r;
        int unsigned c_ins;
        int unsigned c_emp;
        int unsigned c_peek;
        int unsigned c_take;
        int unsigned c_sq;
        c_ins  = insert_heavy ? 45 : 25;
        c_emp  = c_ins + (insert_heavy ? 20 : 15);
        c_peek = c_emp + (insert_heavy ? 8 : 15);
        c_take = c_peek + (insert_heavy ? 12 : 30);
        c_sq   = c_take + 7;
        it.grp = GFIELD_W'($urandom_range(3));
        it.seq = SEQ_W'($urandom);
        it.hdl = HANDLE_W'($urandom_range(16'hFFFF));
        r = $urandom_range(99);
        if (r < c_emp)
        begin
            it.kind  = (r < c_ins) ? KIND_INSERT : KIND_EMP_INSERT;
            next_seq = next_seq + SEQ_W'($urandom_range(1, 3));
            it.seq   = next_seq;
        end
        else if (r < c_peek)
        begin
            it.kind = KIND_PEEK;
        end
        else if (r < c_take)
        begin
            it.kind = KIND_TAKE;
        end
        else if (r < c_sq)
        begin
            it.kind  = KIND_SQUASH;
            it.seq   = next_seq - SEQ_W'($urandom_range(0, 12));
            next_seq = it.seq;
        end
        else if (r < 97)
        begin
            // out-of-order insert with an arbitrary sequence number
            it.kind = KIND_INSERT;
        end
        else if (r < 99)
        begin
            it.kind = KIND_SQUASH;
        end
        else
        begin
            it.kind = KIND_W'($urandom_range(KIND_UNUSED_C, KIND_UNUSED_A));
        end
        return it;
    endfunction

    task automatic send_word(input queue_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= it.kind;
        group    <= it.grp;
        seq_num  <= it.seq;
        handle   <= it.hdl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(it);
        words_in++;
        kind_seen[it.kind]++;
    endtask

    task automatic write_cfg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every predicted word, then let a squash finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_all(input logic [CDATA_W-1:0] lim, input logic [CDATA_W-1:0] md,
                             input logic [CDATA_W-1:0] fa);
        write_cfg(CFG_FILL_LIMIT, lim);
        write_cfg(CFG_MULDIV_GROUP, md);
        write_cfg(CFG_FPADD_GROUP, fa);
    endtask

    initial
    begin
        logic [CDATA_W-1:0] ph_limit [PHASES];
        logic [CDATA_W-1:0] ph_muldiv [PHASES];
        logic [CDATA_W-1:0] ph_fpadd [PHASES];
        ph_limit  = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd16, 5'd16, 5'd8, 5'd2};
        ph_muldiv = '{5'd1,  5'd0, 5'd2,  5'd3, 5'd1, 5'd0,  5'd2,  5'd1, 5'd3};
        ph_fpadd  = '{5'd2,  5'd3, 5'd1,  5'd3, 5'd2, 5'd0,  5'd3,  5'd0, 5'd1};
        sb = new();
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = '0;
        group     = '0;
        seq_num   = '0;
        handle    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty heads, field extremes, empirical choice, squash bounds, no-op kinds
        send_word(op_item(KIND_PEEK,       2'd0, 32'h0,        16'h0));
        send_word(op_item(KIND_TAKE,       2'd3, 32'hFFFF_FFFF, 16'hFFFF));
        send_word(op_item(KIND_INSERT,     2'd0, 32'h0,        16'h0));
        send_word(op_item(KIND_INSERT,     2'd0, 32'hFFFF_FFFF, 16'hFFFF));
        send_word(op_item(KIND_INSERT,     2'd3, 32'd100,      16'h5555));
        send_word(op_item(KIND_EMP_INSERT, 2'd0, 32'd10,       16'hAAAA));
        send_word(op_item(KIND_EMP_INSERT, 2'd3, 32'd11,       16'h1234));
        send_word(op_item(KIND_PEEK,       2'd0, 32'h0,        16'h0));
        send_word(op_item(KIND_SQUASH,     2'd0, 32'h7FFF_FFFF, 16'h0));
        send_word(op_item(KIND_SQUASH,     2'd0, 32'hFFFF_FFFF, 16'h0));
        send_word(op_item(KIND_TAKE,       2'd0, 32'h0,        16'h0));
        send_word(op_item(KIND_TAKE,       2'd0, 32'h0,        16'h0));
        send_word(op_item(KIND_UNUSED_A,   2'd1, 32'h0,        16'h0));
        send_word(op_item(KIND_UNUSED_B,   2'd2, 32'h0,        16'h0));
        send_word(op_item(KIND_UNUSED_C,   2'd3, 32'h0,        16'h0));
        send_word(op_item(KIND_SQUASH,     2'd0, 32'h0,        16'h0));
        settle();

        // Limit of one, both empirical registers on the same group
        write_all(5'd1, 5'd3, 5'd3);
        write_cfg(CFG_SPARE, 5'h1F);
        send_word(op_item(KIND_EMP_INSERT, 2'd0, 32'd7, 16'h0F0F));
        send_word(op_item(KIND_EMP_INSERT, 2'd0, 32'd8, 16'hF0F0));
        send_word(op_item(KIND_INSERT,     2'd3, 32'd9, 16'h0001));
        send_word(op_item(KIND_INSERT,     2'd0, 32'd1, 16'h0002));
        settle();

        // Limit of zero: every queue counts as full
        write_cfg(CFG_FILL_LIMIT, 5'd0);
        send_word(op_item(KIND_INSERT,     2'd1, 32'd3, 16'h0003));
        send_word(op_item(KIND_EMP_INSERT, 2'd1, 32'd4, 16'h0004));
        send_word(op_item(KIND_PEEK,       2'd3, 32'd0, 16'h0));
        send_word(op_item(KIND_TAKE,       2'd3, 32'd0, 16'h0));
        settle();

        // Limit above the queue depth
        write_cfg(CFG_FILL_LIMIT, 5'd31);
        send_word(op_item(KIND_INSERT, 2'd2, 32'd5, 16'h0005));
        send_word(op_item(KIND_TAKE,   2'd0, 32'd0, 16'h0));

        // Random phases across settings and three idling regimes
        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            send_idle_pct = (ph < 3) ? 35 : (ph < 6) ? 76 : 0;
            recv_idle_pct = (ph < 3) ? 76 : (ph < 6) ? 35 : 0;
            if (ph == 7)
            begin
                ph_limit[ph]  = CDATA_W'($urandom_range(1, 16));
                ph_muldiv[ph] = CDATA_W'($urandom_range(3));
                ph_fpadd[ph]  = CDATA_W'($urandom_range(3));
            end
            write_all(ph_limit[ph], ph_muldiv[ph], ph_fpadd[ph]);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                send_word(make_random_item(ph % 2 == 0));
                // hold off results while words keep coming so the block backs up
                if (ph == 6 && n == 8)
                    hold_req = 1'b1;
            end
        end
        settle();

        $display("Covered %0d words (%0d inserts, %0d empirical, %0d squashes), %0d results",
                 words_in, kind_seen[KIND_INSERT], kind_seen[KIND_EMP_INSERT],
                 kind_seen[KIND_SQUASH], sb.words_out);
        $display("Seen %0d dropped inserts and %0d full-group reports over limits 0 to 31",
                 sb.drops, sb.full_reports);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Bound the run well beyond the slowest correct case
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still expected", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hdl/grq_pkg.sv
hdl/grq_cell.sv
hdl/grq_row.sv
hdl/grouped_ready_queue_with_squash.sv
bench/tb_top.sv
